[src/ictf_pkg.sv]
// ----------------------------------------------------------------------------
// ictf_pkg
// Shared types, codes and helper functions of the complementary tilt filter.
// ----------------------------------------------------------------------------
package ictf_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int SQRT_ITERS       = 24;

	localparam logic [1:0] REG_BLEND_ALPHA  = 2'd0;
	localparam logic [1:0] REG_RATE_GAIN    = 2'd1;
	localparam logic [1:0] REG_DEFAULT_STEP = 2'd2;
	localparam logic [1:0] REG_MAX_STEP     = 2'd3;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_INC_A, OP_INC_B, OP_SQ1, OP_SQ2, OP_SQRT,
		OP_CINIT, OP_CORD, OP_CSTORE, OP_BL1, OP_BL2, OP_OUT
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_INC_A, ST_INC_B, ST_SQ1, ST_SQ2, ST_SQRT, ST_CINIT,
		ST_CORD, ST_CSTORE, ST_BL1, ST_BL2, ST_FIN
	} state_t;

	typedef struct packed {
		op_t        op;
		logic       sel;   // 0 pitch, 1 roll
		logic [4:0] iter;
	} cmd_t;

	function automatic logic signed [23:0] atan_q16(input logic [4:0] i);
		logic signed [23:0] r;
		case (i)
			5'd0:  r = 24'sd2949120;
			5'd1:  r = 24'sd1740967;
			5'd2:  r = 24'sd919879;
			5'd3:  r = 24'sd466945;
			5'd4:  r = 24'sd234379;
			5'd5:  r = 24'sd117304;
			5'd6:  r = 24'sd58666;
			5'd7:  r = 24'sd29335;
			5'd8:  r = 24'sd14668;
			5'd9:  r = 24'sd7334;
			5'd10: r = 24'sd3667;
			5'd11: r = 24'sd1833;
			5'd12: r = 24'sd917;
			5'd13: r = 24'sd458;
			5'd14: r = 24'sd229;
			5'd15: r = 24'sd115;
			5'd16: r = 24'sd57;
			5'd17: r = 24'sd29;
			5'd18: r = 24'sd14;
			5'd19: r = 24'sd7;
			5'd20: r = 24'sd4;
			5'd21: r = 24'sd2;
			5'd22: r = 24'sd1;
			default: r = 24'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > 40'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -40'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

[src/ictf_ctrl.sv]
// ----------------------------------------------------------------------------
// ictf_ctrl
// Sequencer: steps the datapath through increments, sqrt, CORDIC and blend.
// ----------------------------------------------------------------------------
module ictf_ctrl #(
	parameter int CORDIC_STEPS = ictf_pkg::CORDIC_STEPS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output ictf_pkg::cmd_t cmd
);
	import ictf_pkg::*;

	localparam logic [4:0] CORD_LAST = 5'(CORDIC_STEPS - 1);
	localparam logic [4:0] SQRT_LAST = 5'(SQRT_ITERS - 1);

	state_t     state_q, state_d;
	logic       sel_q, sel_d;
	logic [4:0] cnt_q, cnt_d;
	logic       out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			sel_q       <= sel_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		sel_d       = sel_q;
		cnt_d       = cnt_q;
		out_valid_d = out_valid_q && !out_ready;
		in_ready    = 1'b0;
		cmd.op      = OP_NONE;
		cmd.sel     = sel_q;
		cmd.iter    = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					sel_d   = 1'b0;
					state_d = ST_INC_A;
				end
			end
			ST_INC_A: begin
				cmd.op = OP_INC_A;
				sel_d  = !sel_q;
				if (sel_q) state_d = ST_INC_B;
			end
			ST_INC_B: begin
				cmd.op = OP_INC_B;
				sel_d  = !sel_q;
				if (sel_q) state_d = ST_SQ1;
			end
			ST_SQ1: begin
				cmd.op  = OP_SQ1;
				state_d = ST_SQ2;
			end
			ST_SQ2: begin
				cmd.op  = OP_SQ2;
				cnt_d   = '0;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.op = OP_SQRT;
				if (cnt_q == SQRT_LAST) begin
					cnt_d   = '0;
					state_d = ST_CINIT;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			ST_CINIT: begin
				cmd.op  = OP_CINIT;
				cnt_d   = '0;
				state_d = ST_CORD;
			end
			ST_CORD: begin
				cmd.op = OP_CORD;
				if (cnt_q == CORD_LAST) begin
					state_d = ST_CSTORE;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			ST_CSTORE: begin
				cmd.op  = OP_CSTORE;
				sel_d   = !sel_q;
				state_d = sel_q ? ST_BL1 : ST_SQ1;
			end
			ST_BL1: begin
				cmd.op  = OP_BL1;
				state_d = ST_BL2;
			end
			ST_BL2: begin
				cmd.op  = OP_BL2;
				sel_d   = !sel_q;
				state_d = sel_q ? ST_FIN : ST_BL1;
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.op      = OP_OUT;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

[src/ictf_datapath.sv]
// ----------------------------------------------------------------------------
// ictf_datapath
// Config registers, shared multiplier, bit-serial sqrt, CORDIC and angle state.
// ----------------------------------------------------------------------------
module ictf_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  ictf_pkg::cmd_t cmd,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [16:0]    cfg_data,
	input  logic [95:0]    in_data,
	output logic [127:0]   out_data,
	output logic           out_flag
);
	import ictf_pkg::*;

	logic [16:0] alpha_cfg_q;
	logic [15:0] gain_q, max_step_q;
	logic [9:0]  def_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_cfg_q <= 17'd62259;
			gain_q      <= 16'd32786;
			def_step_q  <= 10'd50;
			max_step_q  <= 16'd1000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLEND_ALPHA:  alpha_cfg_q <= cfg_data;
				REG_RATE_GAIN:    gain_q      <= cfg_data[15:0];
				REG_DEFAULT_STEP: def_step_q  <= cfg_data[9:0];
				REG_MAX_STEP:     max_step_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic signed [15:0] ax_q, ay_q, az_q, rx_q, ry_q;
	logic [15:0]        dt_q;
	logic               repl_q;
	logic [16:0]        alpha_q;
	logic signed [32:0] t_q [2];
	logic signed [32:0] inc_q [2];
	logic [31:0]        sum_q;
	logic [47:0]        rad_q;
	logic [26:0]        rem_q;
	logic [23:0]        root_q;
	logic signed [27:0] x_q, y_q;
	logic signed [25:0] z_q;
	logic signed [25:0] acc_q [2];
	logic signed [51:0] blend_q;
	logic signed [31:0] fused_q [2];
	logic signed [31:0] integ_q [2];

	logic        [15:0] step_in;
	logic               bad_step;
	logic signed [16:0] num;
	logic signed [15:0] sa, sb;
	logic signed [33:0] prop;
	logic signed [33:0] ma;
	logic signed [17:0] mb;
	logic signed [51:0] prod;
	logic signed [52:0] bsum;
	logic        [26:0] rem_n, trial;
	logic signed [27:0] dx, dy;

	assign step_in  = in_data[95:80];
	assign bad_step = (step_in == 16'd0) || (step_in > max_step_q);
	assign num      = cmd.sel ? -17'(ax_q) : 17'(ay_q);
	assign sa       = cmd.sel ? ay_q : ax_q;
	assign sb       = az_q;
	assign prop     = 34'(fused_q[cmd.sel]) + 34'(inc_q[cmd.sel]);
	assign rem_n    = {rem_q[24:0], rad_q[47:46]};
	assign trial    = {1'b0, root_q, 2'b01};
	assign dx       = y_q >>> cmd.iter;
	assign dy       = x_q >>> cmd.iter;

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_INC_A: begin
				ma = 34'(cmd.sel ? ry_q : rx_q);
				mb = $signed({2'b00, dt_q});
			end
			OP_INC_B: begin
				ma = 34'(t_q[cmd.sel]);
				mb = $signed({2'b00, gain_q});
			end
			OP_SQ1: begin
				ma = 34'(sa);
				mb = 18'(sa);
			end
			OP_SQ2: begin
				ma = 34'(sb);
				mb = 18'(sb);
			end
			OP_BL1: begin
				ma = prop;
				mb = $signed({1'b0, alpha_q});
			end
			OP_BL2: begin
				ma = 34'(acc_q[cmd.sel]);
				mb = $signed(18'd65536 - {1'b0, alpha_q});
			end
			default: ;
		endcase
	end

	assign prod = 52'(ma) * 52'(mb);
	assign bsum = 53'(blend_q) + 53'(prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fused_q[0] <= '0;
			fused_q[1] <= '0;
			integ_q[0] <= '0;
			integ_q[1] <= '0;
		end else begin
			case (cmd.op)
				OP_BL1: integ_q[cmd.sel] <= sat32(40'(integ_q[cmd.sel]) + 40'(inc_q[cmd.sel]));
				OP_BL2: fused_q[cmd.sel] <= sat32(40'(bsum >>> 16));
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				ax_q    <= in_data[15:0];
				ay_q    <= in_data[31:16];
				az_q    <= in_data[47:32];
				rx_q    <= in_data[63:48];
				ry_q    <= in_data[79:64];
				dt_q    <= bad_step ? {6'd0, def_step_q} : step_in;
				repl_q  <= bad_step;
				alpha_q <= (alpha_cfg_q > 17'd65536) ? 17'd65536 : alpha_cfg_q;
			end
			OP_INC_A: t_q[cmd.sel] <= prod[32:0];
			OP_INC_B: inc_q[cmd.sel] <= prod[48:16];
			OP_SQ1:   sum_q <= prod[31:0];
			OP_SQ2: begin
				rad_q  <= {sum_q + prod[31:0], 16'd0};
				rem_q  <= '0;
				root_q <= '0;
			end
			OP_SQRT: begin
				rad_q <= {rad_q[45:0], 2'b00};
				if (rem_n >= trial) begin
					rem_q  <= rem_n - trial;
					root_q <= {root_q[22:0], 1'b1};
				end else begin
					rem_q  <= rem_n;
					root_q <= {root_q[22:0], 1'b0};
				end
			end
			OP_CINIT: begin
				x_q <= $signed({4'd0, root_q});
				y_q <= 28'(num) <<< 8;
				z_q <= '0;
			end
			OP_CORD: begin
				if (!y_q[27]) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + 26'(atan_q16(cmd.iter));
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - 26'(atan_q16(cmd.iter));
				end
			end
			OP_CSTORE: acc_q[cmd.sel] <= (num == 17'sd0) ? 26'sd0 : z_q;
			OP_BL1:    blend_q <= prod;
			OP_OUT: begin
				out_data <= {integ_q[1], integ_q[0], fused_q[1], fused_q[0]};
				out_flag <= repl_q;
			end
			default: ;
		endcase
	end

endmodule

[src/imu_complementary_tilt_filter.sv]
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter
// Complementary pitch/roll filter with CORDIC accel angles and gyro integrals.
// ----------------------------------------------------------------------------
//  channel | dir | signals                       | beat
//  s_      | in  | s_tvalid s_tready s_tdata[95:0] | one raw sample
//  m_      | out | m_tvalid m_tready m_tdata m_tuser | one filtered result
//  cfg_    | in  | cfg_valid cfg_ready cfg_index cfg_data | one register write
//
// One sample runs the 24-step serial sqrt and the CORDIC loop, once for pitch
// and once for roll, on one shared multiplier. A sample is taken only while
// idle; the result waits in an output register, so a stalled m_ side holds
// only the final step. Reset clears state, angles and config to defaults;
// cfg_ready is always high.
module imu_complementary_tilt_filter #(
	parameter int CORDIC_STEPS = ictf_pkg::CORDIC_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// acc_x_sample, acc_y_sample, acc_z_sample, rate_x_sample, rate_y_sample, step_ms
	input  logic [95:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// pitch_out, roll_out, integrated pitch, integrated roll
	output logic [127:0] m_tdata,
	// step_replaced
	output logic [0:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [16:0]  cfg_data
);
	import ictf_pkg::*;

	cmd_t cmd;

	assign cfg_ready = 1'b1;

	ictf_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	ictf_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_tdata),
		.out_data  (m_tdata),
		.out_flag  (m_tuser[0])
	);

endmodule
